[hdl/dss_pkg.sv]
// package for the dashed segment splitter: constants, types and state encodings
package dss_pkg;

  localparam int COORD_BITS_DEF = 8;
  localparam int COORD_BITS_MAX = 12;
  localparam int PHASE_BITS     = 7;
  localparam int PAT_BITS       = 6;
  localparam int MIN_PAT_LEN    = 4;
  localparam int MAX_RESULTS    = 48;
  localparam int CNT_BITS       = 6;
  localparam int FRAC_BITS      = 8;
  // radicand of the length root at the widest coordinates: (dx*dx + dy*dy) << 16
  localparam int DIV_NUM_BITS   = 2*COORD_BITS_MAX + 2 + 2*FRAC_BITS;
  localparam int DIV_DEN_BITS   = 24;

  localparam logic CFG_DASH_LENGTH = 1'b0;
  localparam logic CFG_GAP_LENGTH  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT,
    ST_PHASE,
    ST_STEP,
    ST_DIV_A,
    ST_DIV_B,
    ST_EMIT,
    ST_ADV,
    ST_LAST
  } dss_state_t;

  // request into the shared divider
  typedef struct packed {
    logic                    start;
    logic [DIV_NUM_BITS-1:0] num;
    logic [DIV_DEN_BITS-1:0] den;
  } dss_div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
  } dss_div_rsp_t;

endpackage

[hdl/dashed_segment_splitter.sv]
// dashed segment splitter top level: sequencer around one shared divide/root unit
// sequence: accept the segment and take the length root, fold the phase, then step through
// the gaps and the visible dashes (four divides for each dash that is emitted)
// throughput: one segment at a time; in_tready rises again once the last beat is in the output
// register; result stalls add to the time; reset (rst_n low, synchronous): lengths 4, phase 0
module dashed_segment_splitter
  import dss_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // start_x, start_y, end_x, end_y
  input  logic [4*COORD_BITS-1:0]      in_tdata,
  // restart_pattern
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // dash_x0, dash_y0, dash_x1, dash_y1
  output logic [4*COORD_BITS-1:0]      out_tdata,
  // last_dash
  output logic                         out_tlast,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [PAT_BITS-1:0]          cfg_wdata
);

  localparam int CB  = COORD_BITS;
  localparam int LB  = CB + FRAC_BITS + 1;  // length in q.8 with headroom

  dss_state_t state_r, state_nxt;

  logic [PAT_BITS-1:0]   dash_len_r, gap_len_r;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;

  logic [CB-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [CB-1:0] adx, ady;
  logic [LB-1:0] len_r, len_nxt;
  logic [LB-1:0] trav_r, trav_nxt, step_r, step_nxt;
  logic          on_r, on_nxt, emitted_any_r, emitted_any_nxt, pend_r, pend_nxt;
  logic [CNT_BITS-1:0] n_r, n_nxt;
  logic          ax_r, ax_nxt;        // 0: x axis divide, 1: y axis divide
  logic          endp_r, endp_nxt;    // 0: start point, 1: end point
  logic [CB-1:0] p_r [4];
  logic [CB-1:0] p_nxt [4];
  logic [CB-1:0] hold_r [4];
  logic [CB-1:0] hold_nxt [4];
  logic [CB-1:0] obuf_r [4];
  logic [CB-1:0] obuf_nxt [4];
  logic          hold_last_r, hold_last_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [PAT_BITS:0]   dash_e, gap_e, period;
  logic [PHASE_BITS:0] pos;
  logic [LB-1:0]       full_step;
  logic [2*CB+1:0]     d2;
  logic [CB-1:0]       s_sel, e_sel, mag;
  logic [LB-1:0]       pt_dist;
  logic [CB+LB-1:0]    prod;

  dss_div_req_t req;
  dss_div_rsp_t rsp;
  logic         sqrt_mode;

  dss_div u_div (.clk(clk), .rst_n(rst_n), .sqrt_mode(sqrt_mode), .req(req), .rsp(rsp));

  assign dash_e = (dash_len_r < PAT_BITS'(MIN_PAT_LEN)) ? (PAT_BITS+1)'(MIN_PAT_LEN)
                                                          : {1'b0, dash_len_r};
  assign gap_e  = (gap_len_r < PAT_BITS'(MIN_PAT_LEN)) ? (PAT_BITS+1)'(MIN_PAT_LEN)
                                                         : {1'b0, gap_len_r};
  assign period = dash_e + gap_e;
  // phase is at most 127 and period at least 8: pos needs no reduction here, since the
  // sequencer reduces the phase one subtract per cycle in ST_PHASE
  assign pos    = {1'b0, phase_r};

  assign adx = (ex_r >= sx_r) ? ex_r - sx_r : sx_r - ex_r;
  assign ady = (ey_r >= sy_r) ? ey_r - sy_r : sy_r - ey_r;
  assign d2  = (2*CB+2)'(adx * adx) + (2*CB+2)'(ady * ady);

  // pixels left in the current dash or gap, in q.8
  assign full_step = LB'({(on_r ? dash_e - pos[PAT_BITS:0] : period - pos[PAT_BITS:0]),
                          8'd0});

  // coordinate select for the divide in flight
  assign s_sel   = ax_r ? sy_r : sx_r;
  assign e_sel   = ax_r ? ey_r : ex_r;
  assign mag     = (e_sel >= s_sel) ? e_sel - s_sel : s_sel - e_sel;
  assign pt_dist = endp_r ? trav_r + step_r : trav_r;
  assign prod    = mag * pt_dist;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r; phase_nxt = phase_r; len_nxt = len_r;
    trav_nxt = trav_r; step_nxt = step_r; on_nxt = on_r; n_nxt = n_r;
    ax_nxt = ax_r; endp_nxt = endp_r; pend_nxt = pend_r;
    emitted_any_nxt = emitted_any_r;
    p_nxt = p_r; hold_nxt = hold_r; obuf_nxt = obuf_r; hold_last_nxt = hold_last_r;
    out_valid_nxt = out_valid_r;
    req = '0; sqrt_mode = 1'b0;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) phase_nxt = '0;
          state_nxt = ST_SQRT;
          n_nxt = '0; trav_nxt = '0; emitted_any_nxt = 1'b0; pend_nxt = 1'b0;
        end
      end
      ST_SQRT: begin
        if (!rsp.busy && !rsp.done && !pend_r) begin
          req.start = 1'b1; sqrt_mode = 1'b1;
          req.num = DIV_NUM_BITS'({d2, 16'd0});
          pend_nxt = 1'b1;
        end else if (rsp.done) begin
          pend_nxt = 1'b0;
          len_nxt = LB'(rsp.quot);
          if (rsp.quot < 32'd256) state_nxt = ST_IDLE;
          else state_nxt = ST_PHASE;
        end
      end
      ST_PHASE: begin
        // reduce stored phase modulo the period, one subtract a cycle
        if ({1'b0, phase_r} >= PHASE_BITS'(period) + 8'd0)
          phase_nxt = PHASE_BITS'(phase_r - PHASE_BITS'(period));
        else
          state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (trav_r >= len_r) begin
          state_nxt = ST_LAST;
        end else begin
          on_nxt = pos < PHASE_BITS'(dash_e) + 8'd0;
          state_nxt = ST_DIV_A;
          ax_nxt = 1'b0; endp_nxt = 1'b0;
        end
      end
      ST_DIV_A: begin
        // on_r now valid: work out the clipped step once
        step_nxt = ((LB+1)'(trav_r) + (LB+1)'(full_step) > (LB+1)'(len_r)) ? len_r - trav_r
                                                                             : full_step;
        if (on_r && n_r < CNT_BITS'(MAX_RESULTS)) state_nxt = ST_DIV_B;
        else state_nxt = ST_ADV;
      end
      ST_DIV_B: begin
        // four divides per dash: x0, y0, x1, y1
        if (!rsp.busy && !rsp.done && !pend_r) begin
          req.start = 1'b1;
          req.num = DIV_NUM_BITS'(prod);
          req.den = DIV_DEN_BITS'(len_r);
          pend_nxt = 1'b1;
        end else if (rsp.done) begin
          pend_nxt = 1'b0;
          p_nxt[{endp_r, ax_r}] = (e_sel >= s_sel) ? CB'(s_sel + CB'(rsp.quot))
                                                    : CB'(s_sel - CB'(rsp.quot));
          ax_nxt = ~ax_r;
          if (ax_r) endp_nxt = ~endp_r;
          if (ax_r && endp_r) state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // one dash is held back so the last one can be flagged
        if (!out_valid_r || out_tready) begin
          if (emitted_any_r) begin
            out_valid_nxt = 1'b1;
            obuf_nxt = hold_r;
            hold_last_nxt = 1'b0;
          end
          hold_nxt = p_r;
          emitted_any_nxt = 1'b1;
          n_nxt = n_r + 1'b1;
          state_nxt = ST_ADV;
        end
      end
      ST_ADV: begin
        trav_nxt = trav_r + step_r;
        phase_nxt = PHASE_BITS'((pos + PHASE_BITS'(step_r >> FRAC_BITS)) >= period
                    ? pos + PHASE_BITS'(step_r >> FRAC_BITS) - period
                    : pos + PHASE_BITS'(step_r >> FRAC_BITS));
        state_nxt = ST_STEP;
      end
      ST_LAST: begin
        if (!emitted_any_r) state_nxt = ST_IDLE;
        else if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          obuf_nxt = hold_r;
          hold_last_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= '0;
      dash_len_r <= PAT_BITS'(MIN_PAT_LEN);
      gap_len_r  <= PAT_BITS'(MIN_PAT_LEN);
      out_valid_r <= 1'b0;
      pend_r <= 1'b0;
      emitted_any_r <= 1'b0;
      n_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r <= pend_nxt;
      emitted_any_r <= emitted_any_nxt;
      n_r <= n_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DASH_LENGTH: dash_len_r <= cfg_wdata;
          CFG_GAP_LENGTH:  gap_len_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
    if (state_r == ST_IDLE && in_tvalid) begin
      sx_r <= in_tdata[CB-1:0];
      sy_r <= in_tdata[2*CB-1:CB];
      ex_r <= in_tdata[3*CB-1:2*CB];
      ey_r <= in_tdata[4*CB-1:3*CB];
    end
    len_r <= len_nxt; trav_r <= trav_nxt; step_r <= step_nxt; on_r <= on_nxt;
    ax_r <= ax_nxt; endp_r <= endp_nxt; p_r <= p_nxt; hold_r <= hold_nxt;
    obuf_r <= obuf_nxt;
    hold_last_r <= hold_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {obuf_r[3], obuf_r[2], obuf_r[1], obuf_r[0]};
  assign out_tlast  = hold_last_r;

  // no new segment while the sequencer is busy
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("accept while busy");
  // a stalled beat is not overwritten
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> out_valid_r && $stable(out_tdata))
    else $error("result overwritten");
  // phase stays inside the pattern once a step starts
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> ({1'b0, phase_r} < period + 8'd0)) else $error("phase range");

endmodule

[hdl/dss_div.sv]
// shared restoring divider, one quotient bit per cycle, also used for square root
module dss_div
  import dss_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         sqrt_mode,
  input  dss_div_req_t req,
  output dss_div_rsp_t rsp
);

  logic [31:0] q_r, q_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [DIV_NUM_BITS-1:0] n_r, n_nxt;
  logic [DIV_DEN_BITS-1:0] d_r, d_nxt;
  logic        sq_r, sq_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [33:0] trial;
  logic [33:0] sh;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; n_nxt = n_r; d_nxt = d_r; sq_nxt = sq_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    trial = '0; sh = '0;
    if (req.start) begin
      q_nxt = '0; rem_nxt = '0; n_nxt = req.num; d_nxt = req.den; sq_nxt = sqrt_mode;
      cnt_nxt = sqrt_mode ? 6'(DIV_NUM_BITS / 2) : 6'(DIV_NUM_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sq_r) begin
        // two radicand bits per step
        sh = {rem_r[31:0], n_r[DIV_NUM_BITS-1:DIV_NUM_BITS-2]};
        trial = {q_r[31:0], 2'b01};
        n_nxt = {n_r[DIV_NUM_BITS-3:0], 2'b00};
      end else begin
        sh = {rem_r[32:0], n_r[DIV_NUM_BITS-1]};
        trial = 34'(d_r);
        n_nxt = {n_r[DIV_NUM_BITS-2:0], 1'b0};
      end
      if (sh >= trial) begin
        rem_nxt = sh - trial;
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; n_r <= n_nxt; d_r <= d_nxt; sq_r <= sq_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule
